// ===== hdl/itp_pkg.sv =====
// shared types, character codes and helper functions for the infix to postfix converter
// no dependencies; the top level, sequencer, output stage and testbench refer to it by scoped names
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	// ascii characters the converter recognizes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_ADD    = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SUB    = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNMATCHED = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	typedef enum logic [2:0] {
		OP_MUL, OP_DIV, OP_COMMA, OP_ADD, OP_SUB, OP_SEMI, OP_OPEN, OP_NONE
	} op_code_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LEAD, ST_RD, ST_POP, ST_PUSH, ST_TERM
	} state_t;

	// how far a pop sequence walks down the stack
	typedef enum logic [1:0] {
		PM_ONE, PM_OPEN, PM_ALL, PM_DROP
	} pop_mode_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic [1:0] status;
		logic       last;
	} emit_t;

	function automatic op_code_t char_code(input logic [7:0] c);
		op_code_t r;
		unique case (c)
			CH_MUL:   r = OP_MUL;
			CH_DIV:   r = OP_DIV;
			CH_COMMA: r = OP_COMMA;
			CH_ADD:   r = OP_ADD;
			CH_SUB:   r = OP_SUB;
			CH_SEMI:  r = OP_SEMI;
			CH_OPEN:  r = OP_OPEN;
			default:  r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] code_char(input op_code_t op);
		logic [7:0] r;
		unique case (op)
			OP_MUL:   r = CH_MUL;
			OP_DIV:   r = CH_DIV;
			OP_COMMA: r = CH_COMMA;
			OP_ADD:   r = CH_ADD;
			OP_SUB:   r = CH_SUB;
			OP_SEMI:  r = CH_SEMI;
			OP_OPEN:  r = CH_OPEN;
			default:  r = CH_NUL;
		endcase
		return r;
	endfunction

	function automatic logic is_high(input op_code_t op);
		return (op == OP_MUL) || (op == OP_DIV) || (op == OP_COMMA);
	endfunction

	function automatic logic is_low(input op_code_t op);
		return (op == OP_ADD) || (op == OP_SUB) || (op == OP_SEMI);
	endfunction

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c == CH_USCORE) ||
			(c >= CH_ZERO && c <= CH_NINE) || (c == CH_DOT);
	endfunction

endpackage

// ===== hdl/itp_in_if.sv =====
// input channel of the converter: one expression character per transfer
// no dependencies
interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expr;

	modport source (output valid, output in_char, output end_of_expr, input ready);
	modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== hdl/itp_out_if.sv =====
// output channel of the converter: one postfix character per transfer
// no dependencies
interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [1:0] status;
	logic       last_of_run;

	modport source (output valid, output out_char, output status, output last_of_run,
		input ready);
	modport sink (input valid, input out_char, input status, input last_of_run,
		output ready);
endinterface

// ===== hdl/infix_to_postfix_converter.sv =====
// Infix to postfix converter. One expression character is taken per transfer on expr; results
// leave on postfix one character per transfer, the final one of each input marked by
// last_of_run. An operand is emitted as itself; an operator emits a space, then the entries it
// pops, then is pushed; '(' is pushed, ')' pops the entries above the matching '(' and drops it,
// an ignored character emits nothing, and an end item flushes the stack, then the terminator.
// Each popped entry costs a read of the operator stack ram followed by the pop itself;
// downstream stalls hold the walk until the output stage has room.
// top level; depends on itp_pkg, itp_in_if, itp_out_if, itp_ram, itp_out_stage and itp_seq
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	itp_in_if.sink    expr,
	itp_out_if.source postfix
);

	localparam int AW = $clog2(STACK_DEPTH);

	itp_pkg::emit_t emit;
	logic           can_emit;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [2:0]     ram_wdata, ram_rdata;

	itp_seq #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (expr.valid),
		.in_char     (expr.in_char),
		.end_of_expr (expr.end_of_expr),
		.in_ready    (expr.ready),
		.can_emit    (can_emit),
		.emit        (emit),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	itp_ram #(
		.WIDTH(3),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	itp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.can_emit (can_emit),
		.postfix  (postfix)
	);

endmodule

// ===== hdl/itp_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/itp_out_stage.sv =====
// output register of the converter, parts the sequencer from the downstream ready
// depends on itp_pkg and itp_out_if
module itp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  itp_pkg::emit_t     emit,
	output logic               can_emit,
	itp_out_if.source          postfix
);

	logic       valid_q;
	logic [7:0] char_q;
	logic [1:0] status_q;
	logic       last_q;

	assign can_emit = !valid_q || postfix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
		end else if (postfix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			char_q   <= emit.ch;
			status_q <= emit.status;
			last_q   <= emit.last;
		end
	end

	assign postfix.valid       = valid_q;
	assign postfix.out_char    = char_q;
	assign postfix.status      = status_q;
	assign postfix.last_of_run = last_q;

endmodule

// ===== hdl/itp_seq.sv =====
// sequencer of the converter: decodes a character, walks the operator stack one entry
// at a time through the stack ram and hands characters to the output stage
// depends on itp_pkg; drives an itp_ram instance and an itp_out_stage at the top level
module itp_seq #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [7:0]                     in_char,
	input  logic                           end_of_expr,
	output logic                           in_ready,
	input  logic                           can_emit,
	output itp_pkg::emit_t                 emit,
	output logic                           ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
	output logic [2:0]                     ram_wdata,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
	input  logic [2:0]                     ram_rdata
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	itp_pkg::state_t    state_q, state_d;
	itp_pkg::pop_mode_t mode_q;
	itp_pkg::op_code_t  top_q, push_code_q, in_code, next_top;
	logic [CW-1:0]      count_q, open_q, cnt_m2;
	logic [1:0]         err_q, status_q, acc_err, acc_raise;
	logic [7:0]         lead_char_q;
	logic               lead_last_q, pop_pend_q, push_pend_q, close_q;

	logic accept, empty, full, top_hi, top_lo, top_open;
	logic in_hi, in_lo, in_close, in_operand, acc_pop, acc_push;
	logic last_pop, stop, to_drop, pop_fire, push_fire;
	itp_pkg::pop_mode_t acc_mode;

	assign empty    = (count_q == '0);
	assign full     = (count_q == DEPTH_C);
	assign top_hi   = !empty && itp_pkg::is_high(top_q);
	assign top_lo   = !empty && itp_pkg::is_low(top_q);
	assign top_open = !empty && (top_q == itp_pkg::OP_OPEN);
	assign cnt_m2   = count_q - CW'(2);
	assign next_top = itp_pkg::op_code_t'(ram_rdata);

	assign in_code    = itp_pkg::char_code(in_char);
	assign in_hi      = itp_pkg::is_high(in_code);
	assign in_lo      = itp_pkg::is_low(in_code);
	assign in_close   = (in_char == itp_pkg::CH_CLOSE);
	assign in_operand = itp_pkg::is_operand(in_char);

	assign in_ready = (state_q == itp_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// decisions taken when a character is accepted
	assign acc_pop  = (in_hi && top_hi) || (in_lo && (top_hi || top_lo));
	assign acc_push = in_hi || in_lo || (in_code == itp_pkg::OP_OPEN);

	always_comb begin
		acc_raise = itp_pkg::STAT_OK;
		if (in_close && open_q == '0) begin
			acc_raise = itp_pkg::STAT_UNMATCHED;
		end else if (acc_push && !acc_pop && full) begin
			acc_raise = itp_pkg::STAT_OVERFLOW;
		end
		acc_err = (err_q != itp_pkg::STAT_OK) ? err_q : acc_raise;

		if (end_of_expr) begin
			acc_mode = itp_pkg::PM_ALL;
		end else if (in_close) begin
			acc_mode = top_open ? itp_pkg::PM_DROP : itp_pkg::PM_OPEN;
		end else if (in_lo && top_hi) begin
			acc_mode = itp_pkg::PM_OPEN;
		end else begin
			acc_mode = itp_pkg::PM_ONE;
		end
	end

	// pop walk stops at the bottom, at a '(' for an open-bounded walk, or after one entry
	assign last_pop = (count_q == CW'(1));
	assign stop     = (mode_q == itp_pkg::PM_ONE) || (mode_q == itp_pkg::PM_DROP) || last_pop ||
		(mode_q == itp_pkg::PM_OPEN && next_top == itp_pkg::OP_OPEN);
	assign to_drop  = close_q && (mode_q == itp_pkg::PM_OPEN) && !last_pop;

	always_comb begin
		state_d   = state_q;
		emit      = '0;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = push_code_q;
		ram_raddr = cnt_m2[AW-1:0];
		pop_fire  = 1'b0;
		push_fire = 1'b0;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				if (accept) begin
					if (end_of_expr) begin
						state_d = empty ? itp_pkg::ST_TERM : itp_pkg::ST_RD;
					end else if (in_operand || in_hi || in_lo) begin
						state_d = itp_pkg::ST_LEAD;
					end else if (in_code == itp_pkg::OP_OPEN) begin
						state_d = itp_pkg::ST_PUSH;
					end else if (in_close && !empty) begin
						state_d = itp_pkg::ST_RD;
					end
				end
			end
			itp_pkg::ST_LEAD: begin
				if (can_emit) begin
					emit = '{valid: 1'b1, ch: lead_char_q, status: status_q, last: lead_last_q};
					if (pop_pend_q) begin
						state_d = itp_pkg::ST_RD;
					end else if (push_pend_q) begin
						state_d = itp_pkg::ST_PUSH;
					end else begin
						state_d = itp_pkg::ST_IDLE;
					end
				end
			end
			itp_pkg::ST_RD: begin
				state_d = itp_pkg::ST_POP;
			end
			itp_pkg::ST_POP: begin
				if (mode_q == itp_pkg::PM_DROP || can_emit) begin
					pop_fire = 1'b1;
					emit = '{valid: (mode_q != itp_pkg::PM_DROP),
						ch: itp_pkg::code_char(top_q), status: status_q,
						last: stop && (mode_q != itp_pkg::PM_ALL)};
					if (!stop) begin
						state_d = itp_pkg::ST_RD;
					end else if (mode_q == itp_pkg::PM_ALL) begin
						state_d = itp_pkg::ST_TERM;
					end else if (to_drop) begin
						state_d = itp_pkg::ST_RD;
					end else if (push_pend_q) begin
						state_d = itp_pkg::ST_PUSH;
					end else begin
						state_d = itp_pkg::ST_IDLE;
					end
				end
			end
			itp_pkg::ST_PUSH: begin
				// a push onto a full stack is dropped, its status was raised on accept
				push_fire = !full;
				ram_we    = !full;
				state_d   = itp_pkg::ST_IDLE;
			end
			itp_pkg::ST_TERM: begin
				if (can_emit) begin
					emit = '{valid: 1'b1, ch: itp_pkg::CH_NUL, status: status_q, last: 1'b1};
					state_d = itp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			open_q      <= '0;
			err_q       <= itp_pkg::STAT_OK;
			mode_q      <= itp_pkg::PM_ONE;
			pop_pend_q  <= 1'b0;
			push_pend_q <= 1'b0;
			close_q     <= 1'b0;
			lead_last_q <= 1'b0;
		end else if (accept) begin
			err_q       <= end_of_expr ? itp_pkg::STAT_OK : acc_err;
			mode_q      <= acc_mode;
			pop_pend_q  <= !end_of_expr && acc_pop;
			push_pend_q <= !end_of_expr && acc_push;
			close_q     <= !end_of_expr && in_close;
			lead_last_q <= in_operand || !acc_pop;
		end else if (pop_fire) begin
			count_q <= count_q - CW'(1);
			if (top_q == itp_pkg::OP_OPEN) begin
				open_q <= open_q - CW'(1);
			end
			if (stop && to_drop) begin
				mode_q <= itp_pkg::PM_DROP;
			end
		end else if (push_fire) begin
			count_q <= count_q + CW'(1);
			if (push_code_q == itp_pkg::OP_OPEN) begin
				open_q <= open_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= end_of_expr ? err_q : acc_err;
			lead_char_q <= in_operand ? in_char : itp_pkg::CH_SPACE;
			push_code_q <= in_code;
		end
		if (pop_fire) begin
			top_q <= next_top;
		end else if (push_fire) begin
			top_q <= push_code_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count beyond depth");

	a_open_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= count_q)
		else $error("more open marks than stack entries");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itp_pkg::ST_POP) |-> (count_q != '0))
		else $error("pop from an empty stack");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_expr) |=> (err_q == itp_pkg::STAT_OK))
		else $error("status not cleared after end item");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> can_emit)
		else $error("result written over a waiting result");

endmodule

// ===== verif/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 1ps
// testbench for infix_to_postfix_converter: directed and random expressions checked against
// a shunting yard predictor of the operator stack; depends on itp_pkg, itp_in_if, itp_out_if and the converter
module infix_to_postfix_converter_tb;

	localparam int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF;
	localparam int RANDOM_CHARS = 200;

	typedef struct {
		logic [7:0] ch;
		logic [1:0] status;
		logic       last;
	} postfix_char_t;

	logic clk = 1'b0;
	logic arst_n;

	itp_in_if  expr ();
	itp_out_if postfix ();

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.expr(expr),
		.postfix(postfix)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted converter state
	itp_pkg::op_code_t op_stack [STACK_DEPTH];
	int                op_depth = 0;
	logic [1:0]        sticky_status = itp_pkg::STAT_OK;

	postfix_char_t postfix_due [$];

	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	int stall_left = 0;
	int mismatches = 0;
	int checked_chars = 0;
	int active_chars = 0;

	function automatic int pick_gap(input bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic itp_pkg::op_code_t op_of(input logic [7:0] ch);
		case (ch)
			itp_pkg::CH_MUL:   return itp_pkg::OP_MUL;
			itp_pkg::CH_DIV:   return itp_pkg::OP_DIV;
			itp_pkg::CH_COMMA: return itp_pkg::OP_COMMA;
			itp_pkg::CH_ADD:   return itp_pkg::OP_ADD;
			itp_pkg::CH_SUB:   return itp_pkg::OP_SUB;
			itp_pkg::CH_SEMI:  return itp_pkg::OP_SEMI;
			itp_pkg::CH_OPEN:  return itp_pkg::OP_OPEN;
			default:           return itp_pkg::OP_NONE;
		endcase
	endfunction

	function automatic logic [7:0] char_of(input itp_pkg::op_code_t op);
		case (op)
			itp_pkg::OP_MUL:   return itp_pkg::CH_MUL;
			itp_pkg::OP_DIV:   return itp_pkg::CH_DIV;
			itp_pkg::OP_COMMA: return itp_pkg::CH_COMMA;
			itp_pkg::OP_ADD:   return itp_pkg::CH_ADD;
			itp_pkg::OP_SUB:   return itp_pkg::CH_SUB;
			itp_pkg::OP_SEMI:  return itp_pkg::CH_SEMI;
			itp_pkg::OP_OPEN:  return itp_pkg::CH_OPEN;
			default:           return itp_pkg::CH_NUL;
		endcase
	endfunction

	function automatic bit hi_prec(input itp_pkg::op_code_t op);
		return op == itp_pkg::OP_MUL || op == itp_pkg::OP_DIV || op == itp_pkg::OP_COMMA;
	endfunction

	function automatic bit lo_prec(input itp_pkg::op_code_t op);
		return op == itp_pkg::OP_ADD || op == itp_pkg::OP_SUB || op == itp_pkg::OP_SEMI;
	endfunction

	function automatic itp_pkg::op_code_t top_op();
		return (op_depth == 0) ? itp_pkg::OP_NONE : op_stack[op_depth - 1];
	endfunction

	function automatic logic [7:0] pop_op();
		op_depth--;
		return char_of(op_stack[op_depth]);
	endfunction

	// first error wins until the end of the expression
	function automatic void flag(input logic [1:0] s);
		if (sticky_status == itp_pkg::STAT_OK)
			sticky_status = s;
	endfunction

	function automatic void push_op(input itp_pkg::op_code_t op);
		if (op_depth >= STACK_DEPTH) begin
			flag(itp_pkg::STAT_OVERFLOW);
		end else begin
			op_stack[op_depth] = op;
			op_depth++;
		end
	endfunction

	// returns 0 when the character is ignored by the converter
	function automatic bit predict_postfix(input logic [7:0] ch, input logic eoe);
		logic [7:0]        chars [$];
		itp_pkg::op_code_t op;
		itp_pkg::op_code_t top;
		postfix_char_t     item;
		int                k;
		op = op_of(ch);
		top = top_op();
		if (eoe) begin
			while (op_depth > 0)
				chars.push_back(pop_op());
			chars.push_back(itp_pkg::CH_NUL);
		end else if ((ch >= itp_pkg::CH_UPPER_A && ch <= itp_pkg::CH_UPPER_Z) ||
			ch == itp_pkg::CH_USCORE ||
			(ch >= itp_pkg::CH_ZERO && ch <= itp_pkg::CH_NINE) || ch == itp_pkg::CH_DOT) begin
			chars.push_back(ch);
		end else if (hi_prec(op)) begin
			chars.push_back(itp_pkg::CH_SPACE);
			if (hi_prec(top))
				chars.push_back(pop_op());
			push_op(op);
		end else if (lo_prec(op)) begin
			chars.push_back(itp_pkg::CH_SPACE);
			if (hi_prec(top)) begin
				while (op_depth > 0 && top_op() != itp_pkg::OP_OPEN)
					chars.push_back(pop_op());
			end else if (lo_prec(top)) begin
				chars.push_back(pop_op());
			end
			push_op(op);
		end else if (op == itp_pkg::OP_OPEN) begin
			push_op(op);
		end else if (ch == itp_pkg::CH_CLOSE) begin
			while (op_depth > 0 && top_op() != itp_pkg::OP_OPEN)
				chars.push_back(pop_op());
			if (op_depth > 0)
				op_depth--;
			else
				flag(itp_pkg::STAT_UNMATCHED);
		end else begin
			return 1'b0;
		end
		for (k = 0; k < chars.size(); k++) begin
			item.ch = chars[k];
			item.status = sticky_status;
			item.last = (k == chars.size() - 1);
			postfix_due.push_back(item);
		end
		if (eoe)
			sticky_status = itp_pkg::STAT_OK;
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_operand();
		case ($urandom_range(0, 3))
			0:       return itp_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
			1:       return itp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			2:       return itp_pkg::CH_USCORE;
			default: return itp_pkg::CH_DOT;
		endcase
	endfunction

	function automatic logic [7:0] rand_operator(input bit low_only);
		case ($urandom_range(low_only ? 3 : 0, 5))
			0:       return itp_pkg::CH_MUL;
			1:       return itp_pkg::CH_DIV;
			2:       return itp_pkg::CH_COMMA;
			3:       return itp_pkg::CH_ADD;
			4:       return itp_pkg::CH_SUB;
			default: return itp_pkg::CH_SEMI;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// called and returns at a falling edge; valid stays high into the next call
	task automatic send_char(input logic [7:0] ch, input logic eoe = 1'b0);
		int gap;
		gap = pick_gap(src_idle);
		if (gap > 0) begin
			expr.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		expr.valid <= 1'b1;
		expr.in_char <= ch;
		expr.end_of_expr <= eoe;
		@(posedge clk);
		while (!expr.ready)
			@(posedge clk);
		if (predict_postfix(ch, eoe))
			active_chars++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain();
		expr.valid <= 1'b0;
		@(negedge clk);
		while (postfix_due.size() != 0)
			@(negedge clk);
	endtask

	// every operand class and operator, each precedence pairing on the stack
	task automatic test_operands_and_precedence();
		send_text("A+Z-_*0/9;.,");
		send_char(8'hFF, 1'b1);
	endtask

	// unmatched close first, pop stopping at open, ignored bytes, unclosed open flushed
	task automatic test_parentheses();
		send_text(")(A*B+)");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(itp_pkg::CH_SPACE);
		send_char(itp_pkg::CH_OPEN);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_stack_overflow();
		int round;
		int extra;
		for (round = 0; round < 2; round++) begin
			src_idle = (round == 1);
			sink_idle = (round == 1);
			// second round starts with an unmatched close, which must stay the status
			if (round == 1)
				send_char(itp_pkg::CH_CLOSE);
			extra = 0;
			while (extra < 3) begin
				if (op_depth == STACK_DEPTH)
					extra++;
				send_char(itp_pkg::CH_OPEN);
				if ($urandom_range(0, 1)) begin
					send_char(rand_operand());
					send_char(rand_operator(1'b1));
				end
			end
			repeat ($urandom_range(0, 4))
				send_char(itp_pkg::CH_CLOSE);
			send_char(rand_byte(), 1'b1);
			drain();
		end
	endtask

	task automatic test_random_expressions();
		int start;
		int terms;
		int depth;
		int t;
		int r;
		start = active_chars;
		while (active_chars - start < RANDOM_CHARS) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 85) begin
				terms = $urandom_range(1, 6);
				depth = 0;
				for (t = 0; t < terms; t++) begin
					while (depth < 8 && $urandom_range(0, 3) == 0) begin
						send_char(itp_pkg::CH_OPEN);
						depth++;
					end
					repeat ($urandom_range(1, 3))
						send_char(rand_operand());
					while (depth > 0 && $urandom_range(0, 2) == 0) begin
						send_char(itp_pkg::CH_CLOSE);
						depth--;
					end
					if ($urandom_range(0, 7) == 0)
						send_char(itp_pkg::CH_SPACE);
					if (t != terms - 1)
						send_char(rand_operator(1'b0));
				end
				if ($urandom_range(0, 4) != 0)
					repeat (depth) send_char(itp_pkg::CH_CLOSE);
				send_char(rand_byte(), 1'b1);
			end else begin
				// noise and broken fragments
				repeat ($urandom_range(1, 8)) begin
					r = $urandom_range(0, 9);
					if (r < 6)
						send_char(rand_byte());
					else if (r == 6)
						send_char(itp_pkg::CH_CLOSE);
					else if (r == 7)
						send_char(itp_pkg::CH_OPEN);
					else if (r == 8)
						send_char(rand_operator(1'b0));
					else
						send_char(rand_byte(), 1'b1);
				end
			end
		end
	endtask

	// result sink: random stalls, with stretches of none
	always @(negedge clk) begin
		if (!arst_n) begin
			postfix.ready <= 1'b0;
		end else if (stall_left > 0) begin
			postfix.ready <= 1'b0;
			stall_left--;
		end else begin
			postfix.ready <= 1'b1;
			stall_left = pick_gap(sink_idle);
		end
	end

	always @(posedge clk) begin : check_postfix
		postfix_char_t want;
		if (arst_n && postfix.valid && postfix.ready) begin
			checked_chars++;
			if (postfix_due.size() == 0) begin
				$error("unexpected postfix transfer: out_char %h", postfix.out_char);
				mismatches++;
			end else begin
				want = postfix_due.pop_front();
				if (postfix.out_char !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, postfix.out_char);
					mismatches++;
				end
				if (postfix.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, postfix.status);
					mismatches++;
				end
				if (postfix.last_of_run !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last,
						postfix.last_of_run);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		expr.valid = 1'b0;
		expr.in_char = 8'h00;
		expr.end_of_expr = 1'b0;
		postfix.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_operands_and_precedence();
		test_parentheses();
		test_stack_overflow();
		test_random_expressions();
		drain();
		repeat (100) @(negedge clk);
		$display("%0d expression characters taken, %0d postfix characters checked",
			active_chars, checked_chars);
		$display("includes precedence pops, parentheses, unmatched close and stack overflow");
		if (mismatches == 0 && postfix_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/itp_pkg.sv
hdl/itp_in_if.sv
hdl/itp_out_if.sv
hdl/itp_ram.sv
hdl/itp_out_stage.sv
hdl/itp_seq.sv
hdl/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_tb.sv
